FILE: hw/rtl/arm_servo_angle_solver_assert.svh
// ----------------------------------------------------------------------------
// Arm servo angle solver assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ARM_SERVO_ANGLE_SOLVER_ASSERT_SVH
`define ARM_SERVO_ANGLE_SOLVER_ASSERT_SVH

// generic property, checked out of reset
`define ASAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// value within an inclusive range while a word is offered
`define ASAS_ASSERT_RANGE(lbl, clk, rst_n, vld, sig, lo, hi, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld) |-> ((sig) >= (lo)) && ((sig) <= (hi))) else $error(msg);

`endif

FILE: hw/rtl/asas_pkg.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver package
// Shared types, angle constants and the arctangent step table.
// ----------------------------------------------------------------------------
package asas_pkg;

  localparam int CordicSteps = 17;
  localparam int IdxW        = $clog2(CordicSteps);
  localparam int ZW          = 25;
  localparam int AngW        = 32;

  localparam logic signed [AngW-1:0] Deg90  = 32'sd5898240;
  localparam logic signed [AngW-1:0] Deg120 = 32'sd7864320;
  localparam logic signed [AngW-1:0] Deg145 = 32'sd9502720;
  localparam logic signed [AngW-1:0] Deg2   = 32'sd131072;
  localparam logic signed [AngW-1:0] Deg178 = 32'sd11665408;
  localparam logic signed [AngW-1:0] Half   = 32'sd128;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQR,
    B_SUM,
    B_ROOT,
    B_ATAN_LD,
    B_ATAN,
    B_FIN
  } back_state_e;

  // atan(2^-i) in degrees * 65536, using 180/3.1415
  function automatic logic signed [ZW-1:0] atan_entry(logic [IdxW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 25'sd2949207;
      5'd1:    v = 25'sd1741019;
      5'd2:    v = 25'sd919906;
      5'd3:    v = 25'sd466959;
      5'd4:    v = 25'sd234386;
      5'd5:    v = 25'sd117307;
      5'd6:    v = 25'sd58668;
      5'd7:    v = 25'sd29336;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1834;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/asas_in_if.sv
// ----------------------------------------------------------------------------
// Position word channel
// Valid/ready channel carrying hand, elbow and shoulder coordinates.
// ----------------------------------------------------------------------------
interface asas_in_if #(
  parameter int CoordBits = 15
) ();
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] hand_x;
  logic signed [CoordBits-1:0] hand_y;
  logic signed [CoordBits-1:0] hand_z;
  logic signed [CoordBits-1:0] elbow_x;
  logic signed [CoordBits-1:0] elbow_y;
  logic signed [CoordBits-1:0] elbow_z;
  logic signed [CoordBits-1:0] shoulder_x;
  logic signed [CoordBits-1:0] shoulder_y;
  logic signed [CoordBits-1:0] shoulder_z;

  modport source (
    output valid, hand_x, hand_y, hand_z, elbow_x, elbow_y, elbow_z,
           shoulder_x, shoulder_y, shoulder_z,
    input  ready
  );
  modport sink (
    input  valid, hand_x, hand_y, hand_z, elbow_x, elbow_y, elbow_z,
           shoulder_x, shoulder_y, shoulder_z,
    output ready
  );
endinterface

FILE: hw/rtl/asas_out_if.sv
// ----------------------------------------------------------------------------
// Servo angle word channel
// Valid/ready channel carrying four servo angles, degrees times 256.
// ----------------------------------------------------------------------------
interface asas_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] base_angle;
  logic [15:0] shoulder_angle;
  logic [15:0] elbow_angle;
  logic [15:0] wrist_angle;

  modport source (
    output valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
    input  ready
  );
  modport sink (
    input  valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
    output ready
  );
endinterface

FILE: hw/rtl/arm_servo_angle_solver.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver
// Hand, elbow and shoulder positions in, four clamped servo angles out.
// ----------------------------------------------------------------------------
// Each position word yields one angle word (degrees times 256, 2..178 deg).
// The front end takes a word in any cycle while the two-entry queue has room;
// the back end takes one word at a time through one square root unit that
// resolves one root bit per cycle (two horizontal lengths of COORD_BITS + 10
// bits each) and one CORDIC unit that does one of 17 rotations per cycle
// (three arctangents). A finished angle word waits in the output register
// while the next word is being worked.
module arm_servo_angle_solver #(
  parameter int COORD_BITS = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  asas_in_if.sink    in_i,
  asas_out_if.source out_o
);
  import asas_pkg::*;

  localparam int EntW   = 3 + 8 * (COORD_BITS + 1);
  localparam int QDepth = 2;

  logic            push, full, q_valid, q_pop;
  logic [EntW-1:0] ent_in, ent_out;

  asas_front #(.CoordBits(COORD_BITS), .EntW(EntW)) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ent_o  (ent_in)
  );

  asas_fifo #(.Width(EntW), .Depth(QDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ent_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (ent_out)
  );

  asas_back #(.CoordBits(COORD_BITS), .EntW(EntW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (ent_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

FILE: hw/rtl/asas_front.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver front end
// Accepts position words, forms spans and branch flags for the queue.
// ----------------------------------------------------------------------------
module asas_front #(
  parameter int CoordBits = 15,
  parameter int EntW      = 3 + 8 * (CoordBits + 1)
) (
  asas_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output logic [EntW-1:0] ent_o
);
  localparam int DW = CoordBits + 1;

  logic signed [DW-1:0] d_x0, d_z0, d_x1, d_z1, d_y1, d_x2, d_z2, d_y2;
  logic [DW-1:0] a_x0, a_z0, a_x1, a_z1, a_y1, a_x2, a_z2;
  logic pos0, f1, f2;

  function automatic logic signed [DW-1:0] span(logic signed [CoordBits-1:0] a,
                                                logic signed [CoordBits-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_comb begin
    d_x0 = span(in_i.hand_x, in_i.shoulder_x);
    d_z0 = span(in_i.hand_z, in_i.shoulder_z);
    d_x1 = span(in_i.elbow_x, in_i.shoulder_x);
    d_z1 = span(in_i.elbow_z, in_i.shoulder_z);
    d_y1 = span(in_i.elbow_y, in_i.shoulder_y);
    d_x2 = span(in_i.elbow_x, in_i.hand_x);
    d_z2 = span(in_i.elbow_z, in_i.hand_z);
    d_y2 = span(in_i.hand_y, in_i.elbow_y);
    a_x0 = mag(d_x0);
    a_z0 = mag(d_z0);
    a_x1 = mag(d_x1);
    a_z1 = mag(d_z1);
    a_y1 = mag(d_y1);
    a_x2 = mag(d_x2);
    a_z2 = mag(d_z2);
    pos0 = in_i.hand_x > in_i.shoulder_x;
    f1   = in_i.elbow_z < in_i.shoulder_z;
    f2   = in_i.hand_z < in_i.elbow_z;
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign ent_o      = {pos0, f1, f2, a_x0, a_z0, a_x1, a_z1, a_y1, a_x2, a_z2, d_y2};

endmodule

FILE: hw/rtl/asas_fifo.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver queue
// Short first-in first-out buffer between front and back.
// ----------------------------------------------------------------------------
module asas_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/asas_back.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver back end
// Sequencer over one square root unit and one CORDIC unit, with result
// register.
// ----------------------------------------------------------------------------
module asas_back #(
  parameter int CoordBits = 15,
  parameter int EntW      = 3 + 8 * (CoordBits + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  logic [EntW-1:0] q_data_i,
  output logic            q_pop_o,
  asas_out_if.source      out_o
);
  import asas_pkg::*;

  localparam int DW    = CoordBits + 1;
  localparam int RW    = 2 * DW + 17;
  localparam int RW2   = RW + (RW % 2);
  localparam int RB    = RW2 / 2;
  localparam int AW    = RB;
  localparam int CW    = AW + 11;
  localparam int StepN = (RB > CordicSteps) ? RB : CordicSteps;
  localparam int CntW  = $clog2(StepN);

  back_state_e state_q, state_d;

  logic [EntW-1:0] ent_q;
  logic pos0, f1, f2;
  logic [DW-1:0] a_x0, a_z0, a_x1, a_z1, a_y1, a_x2, a_z2;
  logic signed [DW-1:0] d_y2;
  logic [DW-1:0] a_y2;

  logic [1:0]      pass_q;
  logic [CntW-1:0] cnt_q;
  logic            last_root, last_atan;
  logic            pop, out_load;

  logic [2*DW-1:0] sqa_q, sqb_q;
  logic [RW2-1:0]  rad_q;
  logic [RB+1:0]   rem_q;
  logic [RB-1:0]   root_q;
  logic [RB+3:0]   rsh, trial;
  logic [AW-1:0]   xz_q [2];

  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, z_nx, t_res;
  logic                 zero_q, neg_q;
  logic signed [ZW-1:0] at_q [3];
  logic [AW-1:0]        num, den;
  logic                 num_neg;

  logic [DW-1:0]   sq_x, sq_z;
  logic signed [AngW-1:0] t0, t1, t2, ang0, ang1, ang2r, ang2, ang3;

  logic       ov_q;
  logic [15:0] base_q, shoulder_q, elbow_q, wrist_q;

  assign {pos0, f1, f2, a_x0, a_z0, a_x1, a_z1, a_y1, a_x2, a_z2, d_y2} = ent_q;
  assign a_y2 = d_y2[DW-1] ? DW'(-d_y2) : DW'(d_y2);

  assign last_root = cnt_q == CntW'(RB - 1);
  assign last_atan = cnt_q == CntW'(CordicSteps - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:    if (q_valid_i) state_d = B_SQR;
      B_SQR:     state_d = B_SUM;
      B_SUM:     state_d = B_ROOT;
      B_ROOT:    if (last_root) state_d = (pass_q == 2'd0) ? B_SQR : B_ATAN_LD;
      B_ATAN_LD: state_d = B_ATAN;
      B_ATAN:    if (last_atan) state_d = (pass_q == 2'd2) ? B_FIN : B_ATAN_LD;
      B_FIN:     if (!ov_q || out_o.ready) state_d = B_IDLE;
      default:   state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE:  pop = q_valid_i;
      B_FIN:   out_load = !ov_q || out_o.ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign q_pop_o = pop;

  // operand selection
  always_comb begin
    sq_x = (pass_q == 2'd0) ? a_x1 : a_x2;
    sq_z = (pass_q == 2'd0) ? a_z1 : a_z2;
    rsh   = {rem_q, rad_q[RW2-1 -: 2]};
    trial = (RB+4)'({root_q, 2'b01});
    num_neg = 1'b0;
    case (pass_q)
      2'd0: begin
        num = AW'({a_x0, 8'h00});
        den = AW'({a_z0, 8'h00});
      end
      2'd1: begin
        num = xz_q[0];
        den = AW'({a_y1, 8'h00});
      end
      default: begin
        if (f2) begin
          num     = AW'({a_y2, 8'h00});
          den     = xz_q[1];
          num_neg = d_y2[DW-1];
        end else begin
          num = xz_q[1];
          den = AW'({a_y2, 8'h00});
        end
      end
    endcase
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    if (!y_q[CW-1]) begin
      z_nx = z_q + atan_entry(cnt_q[IdxW-1:0]);
    end else begin
      z_nx = z_q - atan_entry(cnt_q[IdxW-1:0]);
    end
    if (zero_q || z_nx[ZW-1]) begin
      t_res = '0;
    end else begin
      t_res = neg_q ? -z_nx : z_nx;
    end
  end

  // final angles
  always_comb begin
    t0    = AngW'(at_q[0]);
    t1    = AngW'(at_q[1]);
    t2    = AngW'(at_q[2]);
    ang0  = pos0 ? Deg90 + t0 : Deg90 - t0;
    ang1  = f1 ? Deg120 - t1 : Deg120;
    ang2r = f2 ? t2 : Deg90 + t2;
    ang3  = Deg90 - ang2r;
    ang2  = ang2r + Deg145 - ang1;
  end

  function automatic logic [15:0] finish(logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] c;
    logic [AngW-1:0] r;
    c = a;
    if (c < Deg2) c = Deg2;
    if (c > Deg178) c = Deg178;
    r = c + Half;
    return r[23:8];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      pass_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        B_IDLE:    pass_q <= '0;
        B_SUM:     cnt_q <= '0;
        B_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_root) pass_q <= (pass_q == 2'd0) ? 2'd1 : 2'd0;
        end
        B_ATAN_LD: cnt_q <= '0;
        B_ATAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_atan) pass_q <= pass_q + 1'b1;
        end
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) ent_q <= q_data_i;
    case (state_q)
      B_SQR: begin
        sqa_q <= sq_x * sq_x;
        sqb_q <= sq_z * sq_z;
      end
      B_SUM: begin
        rad_q  <= RW2'({(2*DW+1)'(sqa_q) + (2*DW+1)'(sqb_q), 16'h0000});
        rem_q  <= '0;
        root_q <= '0;
      end
      B_ROOT: begin
        rad_q <= {rad_q[RW2-3:0], 2'b00};
        if (rsh >= trial) begin
          rem_q  <= (RB+2)'(rsh - trial);
          root_q <= {root_q[RB-2:0], 1'b1};
        end else begin
          rem_q  <= rsh[RB+1:0];
          root_q <= {root_q[RB-2:0], 1'b0};
        end
        if (last_root) xz_q[pass_q[0]] <= (rsh >= trial) ? {root_q[RB-2:0], 1'b1}
                                                         : {root_q[RB-2:0], 1'b0};
      end
      B_ATAN_LD: begin
        x_q    <= CW'({den, 8'h00});
        y_q    <= CW'({num, 8'h00});
        z_q    <= '0;
        zero_q <= (den == '0) || (num == '0);
        neg_q  <= num_neg;
      end
      B_ATAN: begin
        z_q <= z_nx;
        if (!y_q[CW-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
        end
      end
      default: begin
      end
    endcase
    if (state_q == B_ATAN && last_atan) begin
      at_q[pass_q] <= t_res;
    end
    if (out_load) begin
      base_q     <= finish(ang0);
      shoulder_q <= finish(ang1);
      elbow_q    <= finish(ang2);
      wrist_q    <= finish(ang3);
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.base_angle     = base_q;
  assign out_o.shoulder_angle = shoulder_q;
  assign out_o.elbow_angle    = elbow_q;
  assign out_o.wrist_angle    = wrist_q;

endmodule

FILE: hw/rtl/asas_checker.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver checker
// Port-level checks on the angle word channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "arm_servo_angle_solver_assert.svh"

module asas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] base_angle_i,
  input logic [15:0] shoulder_angle_i,
  input logic [15:0] elbow_angle_i,
  input logic [15:0] wrist_angle_i
);

  `ASAS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "angle word dropped while stalled")
  `ASAS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(base_angle_i) && $stable(wrist_angle_i), "angle word changed while stalled")
  `ASAS_ASSERT_RANGE(a_base_rng, clk_i, rst_ni, out_valid_i, base_angle_i, 16'd512, 16'd45568, "base angle outside clamp")
  `ASAS_ASSERT_RANGE(a_shoulder_rng, clk_i, rst_ni, out_valid_i, shoulder_angle_i, 16'd512, 16'd30720, "shoulder angle above 120 degrees")
  `ASAS_ASSERT(a_limb_rng, clk_i, rst_ni, out_valid_i |-> elbow_angle_i >= 16'd512 && elbow_angle_i <= 16'd45568 && wrist_angle_i >= 16'd512 && wrist_angle_i <= 16'd45568, "elbow or wrist angle outside clamp")

endmodule

bind arm_servo_angle_solver asas_checker u_asas_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .base_angle_i     (out_o.base_angle),
  .shoulder_angle_i (out_o.shoulder_angle),
  .elbow_angle_i    (out_o.elbow_angle),
  .wrist_angle_i    (out_o.wrist_angle)
);

FILE: tb/asas_angle_checker.sv
// ----------------------------------------------------------------------------
// Arm servo angle checker
// Watches the position and angle channels, predicts each angle word from the
// accepted position word and compares the two field by field, in order.
// ----------------------------------------------------------------------------
module asas_angle_checker (
  input  logic clk_i,
  input  logic rst_ni,
  asas_in_if   pos_i,
  asas_out_if  ang_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam longint OneDeg = 65536;
  localparam int     Steps  = 17;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] shoulder;
    logic [15:0] elbow;
    logic [15:0] wrist;
  } angle_word_t;

  angle_word_t expected_q[$];

  function automatic longint cordic_gain_free_atan_tab(int i);
    longint tab[Steps] = '{2949207, 1741019, 919906, 466959, 234386, 117307, 58668,
                           29336, 14668, 7334, 3667, 1834, 917, 458, 229, 115, 57};
    return tab[i];
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // floor(sqrt(dx^2 + dz^2)) with 8 fraction bits
  function automatic longint horiz_len(longint dx, longint dz);
    longint unsigned v, r, b;
    v = longint'(dx * dx + dz * dz) << 16;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // degrees * 65536 of num/den, both with 8 fraction bits
  function automatic longint atan_deg(longint num, longint den);
    longint x, y, z, xs, ys;
    z = 0;
    if (den <= 0 || num == 0) return 0;
    x = den <<< 8;
    y = mag(num) <<< 8;
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + cordic_gain_free_atan_tab(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - cordic_gain_free_atan_tab(i);
      end
    end
    if (z < 0) z = 0;
    return (num < 0) ? -z : z;
  endfunction

  function automatic logic [15:0] clamp_round(longint a);
    if (a < 2 * OneDeg) a = 2 * OneDeg;
    if (a > 178 * OneDeg) a = 178 * OneDeg;
    return 16'((a + 128) >> 8);
  endfunction

  function automatic angle_word_t solve_angles(longint hx, longint hy, longint hz,
                                               longint ex, longint ey, longint ez,
                                               longint sx, longint sy, longint sz);
    angle_word_t w;
    longint a0, a1, a2, a3, t, xz;
    t  = atan_deg(mag(hx - sx) <<< 8, mag(hz - sz) <<< 8);
    a0 = (hx > sx) ? 90 * OneDeg + t : 90 * OneDeg - t;
    xz = horiz_len(ex - sx, ez - sz);
    a1 = (ez < sz) ? 60 * OneDeg + atan_deg(xz, mag(ey - sy) <<< 8) : 60 * OneDeg;
    a1 = 180 * OneDeg - a1;
    xz = horiz_len(ex - hx, ez - hz);
    if (hz < ez) a2 = atan_deg((hy - ey) * 256, xz);
    else         a2 = 90 * OneDeg + atan_deg(xz, mag(ey - hy) <<< 8);
    a3 = 90 * OneDeg - a2;
    a2 = a2 + 145 * OneDeg - a1;
    w.base     = clamp_round(a0);
    w.shoulder = clamp_round(a1);
    w.elbow    = clamp_round(a2);
    w.wrist    = clamp_round(a3);
    return w;
  endfunction

  assign pending_o = expected_q.size();

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    angle_word_t got, want;
    if (rst_ni) begin
      if (pos_i.valid && pos_i.ready)
        expected_q.push_back(solve_angles(pos_i.hand_x, pos_i.hand_y, pos_i.hand_z,
                                          pos_i.elbow_x, pos_i.elbow_y, pos_i.elbow_z,
                                          pos_i.shoulder_x, pos_i.shoulder_y,
                                          pos_i.shoulder_z));
      if (ang_i.valid && ang_i.ready) begin
        got = '{ang_i.base_angle, ang_i.shoulder_angle, ang_i.elbow_angle,
                ang_i.wrist_angle};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected angle word %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.base != want.base || got.shoulder != want.shoulder ||
              got.elbow != want.elbow || got.wrist != want.wrist) begin
            $display("%0t: angle mismatch expected b=%0d s=%0d e=%0d w=%0d got b=%0d s=%0d e=%0d w=%0d",
                     $time, want.base, want.shoulder, want.elbow, want.wrist,
                     got.base, got.shoulder, got.elbow, got.wrist);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_arm_servo_angle_solver.sv
// ----------------------------------------------------------------------------
// Arm servo angle solver testbench
// Drives directed and random position words through four idle/stall phases;
// the checker predicts and compares every angle word.
// ----------------------------------------------------------------------------
module tb_arm_servo_angle_solver;

  localparam int CoordBits = 15;
  localparam int MaxC      = 16383;
  localparam int MinC      = -16384;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   fail_count, pending;

  asas_in_if #(.CoordBits(CoordBits)) in_b ();
  asas_out_if                         out_b ();

  arm_servo_angle_solver #(.COORD_BITS(CoordBits)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_b),
    .out_o  (out_b)
  );

  asas_angle_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pos_i        (in_b),
    .ang_i        (out_b),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_b.valid = 1'b0;
    {in_b.hand_x, in_b.hand_y, in_b.hand_z} = '0;
    {in_b.elbow_x, in_b.elbow_y, in_b.elbow_z} = '0;
    {in_b.shoulder_x, in_b.shoulder_y, in_b.shoulder_z} = '0;
    out_b.ready = 1'b0;
  end

  always @(negedge clk_i)
    out_b.ready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_word(int hx, int hy, int hz, int ex, int ey, int ez,
                           int sx, int sy, int sz);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_b.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_b.hand_x     <= CoordBits'(hx);
    in_b.hand_y     <= CoordBits'(hy);
    in_b.hand_z     <= CoordBits'(hz);
    in_b.elbow_x    <= CoordBits'(ex);
    in_b.elbow_y    <= CoordBits'(ey);
    in_b.elbow_z    <= CoordBits'(ez);
    in_b.shoulder_x <= CoordBits'(sx);
    in_b.shoulder_y <= CoordBits'(sy);
    in_b.shoulder_z <= CoordBits'(sz);
    in_b.valid      <= 1'b1;
    do @(posedge clk_i); while (!(in_b.valid && in_b.ready));
    @(negedge clk_i);
  endtask

  function automatic int near(int c, int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    if (v > MaxC) v = MaxC;
    if (v < MinC) v = MinC;
    return v;
  endfunction

  function automatic int any_coord();
    return $urandom_range(0, 32767) - 16384;
  endfunction

  task automatic send_random();
    int sx, sy, sz, ex, ey, ez, pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      // plausible arm pose: elbow near the shoulder, hand near the elbow
      sx = near(0, 1500); sy = near(0, 1500); sz = near(1500, 1500);
      ex = near(sx, 400);  ey = near(sy, 400);  ez = near(sz, 400);
      send_word(near(ex, 400), near(ey, 400), near(ez, 400), ex, ey, ez, sx, sy, sz);
    end else if (pick < 90) begin
      send_word(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                any_coord(), any_coord(), any_coord(), any_coord());
    end else begin
      // shared axes to hit zero spans
      sx = any_coord(); sy = any_coord(); sz = any_coord();
      ex = ($urandom_range(0, 1)) ? sx : any_coord();
      ez = ($urandom_range(0, 1)) ? sz : any_coord();
      send_word(($urandom_range(0, 1)) ? sx : ex, ($urandom_range(0, 1)) ? sy : ey,
                ($urandom_range(0, 1)) ? ez : sz, ex, sy, ez, sx, sy, sz);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC);
    send_word(MinC, MinC, MinC, MinC, MinC, MinC, MinC, MinC, MinC);
    send_word(MaxC, MaxC, MaxC, MinC, MinC, MinC, MinC, MinC, MinC);
    send_word(MinC, MinC, MinC, MaxC, MaxC, MaxC, MaxC, MaxC, MaxC);
    send_word(MaxC, MinC, MinC, MinC, MaxC, MaxC, MinC, MinC, MaxC);
    send_word(MinC, MaxC, MaxC, MaxC, MinC, MinC, MaxC, MaxC, MinC);
    send_word(300, 0, 500, 0, 0, 500, 0, 0, 500);
    send_word(-300, 0, 500, 0, 0, 500, 0, 0, 500);
    send_word(0, 200, 900, 0, 0, 800, 0, 0, 700);
    send_word(100, 50, 600, 50, 300, 700, 0, 0, 1000);
    send_word(100, 400, 600, 50, 300, 900, 0, 300, 1000);
    send_word(100, -200, 500, 100, 0, 800, 100, 0, 1000);
    send_word(0, 0, 1000, 0, 0, 900, 0, 0, 800);
    send_word(1, 1, 1, 0, 0, 0, -1, -1, -1);
    send_word(-1, -1, 2, 0, 0, 1, 1, 1, 0);
    send_word(MaxC, 0, 0, 0, 0, 0, MinC, 0, 0);
    send_word(0, 0, MaxC, 0, 0, MinC, 0, 0, MaxC);

    // hold off until the block has drained
    in_b.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      repeat (420) send_random();
    end
    in_b.valid <= 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
